@@ hdl/wrss_pkg.sv @@
// Shared types, widths and codes of the weighted random server selector.
`timescale 1ns / 1ps

package wrss_pkg;

   localparam int DEF_MAX_SERVERS = 16;
   localparam int NODE_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int RAND_W = 32;
   localparam int ENT_W = NODE_W + WEIGHT_W;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] ADDR_INIT_WEIGHT = 2'd0;

   typedef enum logic [1:0] {
      CMD_CONNECT    = 2'd0,
      CMD_DISCONNECT = 2'd1,
      CMD_SET_WEIGHT = 2'd2,
      CMD_SELECT     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NONE      = 2'd3
   } status_type;

   typedef struct packed {
      logic                start;
      logic [RAND_W-1:0]   dividend;
   } div_req_type;

endpackage

@@ hdl/wrss_if.sv @@
// Request and response channel interfaces of the server selector.
`timescale 1ns / 1ps

interface wrss_req_if;
   import wrss_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [NODE_W-1:0]   node_id;
   logic [WEIGHT_W-1:0] new_weight;
   logic [RAND_W-1:0]   random_value;

   modport source (
      output valid, command, node_id, new_weight, random_value,
      input  ready
   );
   modport sink (
      input  valid, command, node_id, new_weight, random_value,
      output ready
   );
endinterface

interface wrss_rsp_if;
   import wrss_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [NODE_W-1:0] chosen_node;

   modport source (
      output valid, status, chosen_node,
      input  ready
   );
   modport sink (
      input  valid, status, chosen_node,
      output ready
   );
endinterface

@@ hdl/wrss_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module wrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/wrss_mod.sv @@
// Bit-serial remainder unit for the random draw reduction.
`timescale 1ns / 1ps

module wrss_mod #(
   parameter int DIV_W = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wrss_pkg::div_req_type      div_req,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);
   import wrss_pkg::*;

   localparam int STEP_W = $clog2(RAND_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [RAND_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[RAND_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         dvd_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         dvd_in  = {dvd_ff[RAND_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/wrss_seq.sv @@
// Command sequencer: table scans, read-modify-write of entries, response register.
`timescale 1ns / 1ps

module wrss_seq #(
   parameter int MAX_SERVERS = wrss_pkg::DEF_MAX_SERVERS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   wrss_req_if.sink                                      req,
   wrss_rsp_if.source                                    rsp,
   input  logic [wrss_pkg::WEIGHT_W-1:0]                 init_weight,
   output logic                                          ram_wr_en,
   output logic [$clog2(MAX_SERVERS)-1:0]                ram_wr_addr,
   output logic [wrss_pkg::ENT_W-1:0]                    ram_wr_data,
   output logic [$clog2(MAX_SERVERS)-1:0]                ram_rd_addr,
   input  logic [wrss_pkg::ENT_W-1:0]                    ram_rd_data,
   output wrss_pkg::div_req_type                         div_req,
   output logic [wrss_pkg::WEIGHT_W+$clog2(MAX_SERVERS)-1:0] div_divisor,
   input  logic                                          div_done,
   input  logic [wrss_pkg::WEIGHT_W+$clog2(MAX_SERVERS)-1:0] div_rem
);
   import wrss_pkg::*;

   localparam int IDX_W = $clog2(MAX_SERVERS);
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int TOT_W = WEIGHT_W + IDX_W;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_CONNECT = 5'b00010,
      S_SCAN    = 5'b00100,
      S_DIVIDE  = 5'b01000,
      S_REPLY   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [WEIGHT_W-1:0] nw_ff, nw_in;
   logic [RAND_W-1:0]   rand_ff, rand_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic                pass_ff, pass_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [TOT_W-1:0]    draw_ff, draw_in;
   status_type          res_stat_ff, res_stat_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_stat_ff, rsp_stat_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;

   logic [NODE_W-1:0]   d_node;
   logic [WEIGHT_W-1:0] d_weight;
   logic                scan_end;

   assign d_node   = ram_rd_data[ENT_W-1:WEIGHT_W];
   assign d_weight = ram_rd_data[WEIGHT_W-1:0];
   assign scan_end = !rd_vld_ff && !(issue_ff < count_ff);

   assign req.ready   = (state_ff == S_IDLE);
   assign ram_rd_addr = issue_ff[IDX_W-1:0];
   assign div_divisor = total_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      node_in      = node_ff;
      nw_in        = nw_ff;
      rand_in      = rand_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      pass_in      = pass_ff;
      total_in     = total_ff;
      draw_in      = draw_ff;
      res_stat_in  = res_stat_ff;
      res_node_in  = res_node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_node_in  = rsp_node_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_idx_ff;
      ram_wr_data  = ram_rd_data;
      div_req      = '{start: 1'b0, dividend: rand_ff};

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in      = cmd_type'(req.command);
               node_in     = req.node_id;
               nw_in       = req.new_weight;
               rand_in     = req.random_value;
               issue_in    = '0;
               found_in    = 1'b0;
               pass_in     = 1'b0;
               total_in    = '0;
               res_stat_in = STAT_OK;
               res_node_in = '0;
               if (cmd_type'(req.command) == CMD_CONNECT) begin
                  state_in = S_CONNECT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_CONNECT: begin
            if (count_ff == CNT_W'(MAX_SERVERS)) begin
               res_stat_in = STAT_FULL;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = count_ff[IDX_W-1:0];
               ram_wr_data = {node_ff, init_weight};
               count_in    = count_ff + 1'b1;
            end
            state_in = S_REPLY;
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (cmd_ff)
                  CMD_DISCONNECT: begin
                     if (!found_ff && d_node == node_ff) begin
                        found_in = 1'b1;
                     end else if (found_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = rd_idx_ff - 1'b1;
                     end
                  end
                  CMD_SET_WEIGHT: begin
                     if (!found_ff && d_node == node_ff) begin
                        found_in    = 1'b1;
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {d_node, nw_ff};
                     end
                  end
                  CMD_SELECT: begin
                     if (!pass_ff) begin
                        total_in = total_ff + TOT_W'(d_weight);
                     end else if (!found_ff && d_weight != '0) begin
                        if (draw_ff <= TOT_W'(d_weight)) begin
                           found_in    = 1'b1;
                           ram_wr_en   = 1'b1;
                           ram_wr_data = {d_node, d_weight - 1'b1};
                           res_node_in = d_node;
                        end else begin
                           draw_in = draw_ff - TOT_W'(d_weight);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (scan_end) begin
               state_in = S_REPLY;
               case (cmd_ff)
                  CMD_DISCONNECT: begin
                     if (found_ff) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        res_stat_in = STAT_NOT_FOUND;
                     end
                  end
                  CMD_SET_WEIGHT: begin
                     if (!found_ff) begin
                        res_stat_in = STAT_NOT_FOUND;
                     end
                  end
                  CMD_SELECT: begin
                     if (!pass_ff) begin
                        if (total_ff == '0) begin
                           res_stat_in = STAT_NONE;
                        end else begin
                           div_req.start = 1'b1;
                           state_in      = S_DIVIDE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               draw_in  = div_rem + 1'b1;
               issue_in = '0;
               found_in = 1'b0;
               pass_in  = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_node_in  = res_node_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      node_ff     <= node_in;
      nw_ff       <= nw_in;
      rand_ff     <= rand_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      pass_ff     <= pass_in;
      total_ff    <= total_in;
      draw_ff     <= draw_in;
      res_stat_ff <= res_stat_in;
      res_node_ff <= res_node_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_node_ff <= rsp_node_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_stat_ff;
   assign rsp.chosen_node = rsp_node_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SERVERS))
      else $error("entry count beyond table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_wr_en)
      else $error("table write while idle");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == S_SCAN)
      else $error("read data in flight outside a scan");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVIDE)
      else $error("remainder ready while not waiting for it");

   a_reply_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPLY && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not moved to response register");
`endif

endmodule

@@ hdl/weighted_random_server_selector.sv @@
// Top level of the weighted random server selector: CSR port, table RAM, remainder unit.
`timescale 1ns / 1ps

// One command beat is taken at a time and answered by one response beat.
// Connect writes the new entry at the end of the table, or finds it full, and
// then loads its result into the response register. Disconnect and set weight
// walk the table once through the single read port of the table RAM, one
// entry per cycle. Select walks the table twice and reduces the random word in
// a bit-serial remainder unit of 32 steps between the two walks; a select on a
// zero total answers after the first walk. A new command beat is taken the
// cycle after the previous result is loaded into the response register,
// whether or not that result has been taken yet. No clearing pass follows
// reset. initial_weight sits at byte address 0.
module weighted_random_server_selector #(
   parameter int MAX_SERVERS = wrss_pkg::DEF_MAX_SERVERS
) (
   input  logic                        clock,
   input  logic                        reset,
   wrss_req_if.sink                    req_bus,
   wrss_rsp_if.source                  rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [wrss_pkg::CSR_AW-1:0] paddr,
   input  logic [wrss_pkg::CSR_DW-1:0] pwdata,
   output logic [wrss_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import wrss_pkg::*;

   localparam int IDX_W = $clog2(MAX_SERVERS);
   localparam int TOT_W = WEIGHT_W + IDX_W;

   logic [WEIGHT_W-1:0] init_weight_ff, init_weight_in;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENT_W-1:0]    ram_wr_data;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENT_W-1:0]    ram_rd_data;
   div_req_type         div_req;
   logic [TOT_W-1:0]    div_divisor;
   logic                div_done;
   logic [TOT_W-1:0]    div_rem;

   always_comb begin
      init_weight_in = init_weight_ff;
      if (psel && penable && pwrite && paddr == ADDR_INIT_WEIGHT) begin
         init_weight_in = pwdata[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_weight_ff <= '0;
      end else begin
         init_weight_ff <= init_weight_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_INIT_WEIGHT) ? CSR_DW'(init_weight_ff) : '0;

   wrss_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_SERVERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   wrss_mod #(
      .DIV_W (TOT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   wrss_seq #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .init_weight (init_weight_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .div_req     (div_req),
      .div_divisor (div_divisor),
      .div_done    (div_done),
      .div_rem     (div_rem)
   );

endmodule
